// File: rtl/core/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and the CRC byte update for the command frame
// builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

  // Frame layout: seven data bytes, then the CRC high and low bytes.
  localparam int unsigned FRAME_LEN = 9;
  localparam int unsigned CRC_SPAN  = 7;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
  localparam int unsigned POS_W     = $clog2(CRC_SPAN);

  localparam logic [IDX_W-1:0] BYTE_FIRST  = IDX_W'(0);
  localparam logic [IDX_W-1:0] BYTE_CRC_HI = IDX_W'(CRC_SPAN);
  localparam logic [IDX_W-1:0] BYTE_LAST   = IDX_W'(FRAME_LEN - 1);

  // Reflected CRC-16 as used on Modbus links.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register indexes and reset values.
  localparam logic REG_FRAME_ADDRESS  = 1'b0;
  localparam logic REG_FRAME_FUNCTION = 1'b1;

  localparam logic [7:0] FRAME_ADDRESS_RST  = 8'h0C;
  localparam logic [7:0] FRAME_FUNCTION_RST = 8'h02;

  // The seven bytes that the CRC covers, in frame order.
  typedef struct packed {
    logic [7:0] frame_address;
    logic [7:0] frame_function;
    logic [7:0] command_code;
    logic [7:0] value_byte_one;
    logic [7:0] value_byte_two;
    logic [7:0] value_byte_three;
    logic [7:0] value_byte_four;
  } cfb_frame_t;

  // Fold one byte into the CRC, least significant bit first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// File: rtl/core/cfb_cmd_stage.sv
// ----------------------------------------------------------------------------
// cfb_cmd_stage
// Input register: holds one command request, with the header bytes captured
// alongside, until the serialiser is free to take it.
// ----------------------------------------------------------------------------
module cfb_cmd_stage
  import cfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cfb_frame_t in_frame_i,
  input  logic       take_i,
  output logic       cmd_valid_o,
  output cfb_frame_t cmd_frame_o
);

  logic       full_q, full_d;
  cfb_frame_t frame_q;

  // The register frees up in the same cycle the serialiser takes its content.
  assign in_ready_o = !full_q || take_i;
  assign full_d     = in_ready_o ? in_valid_i : full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  // Payload capture; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      frame_q <= in_frame_i;
    end
  end

  assign cmd_valid_o = full_q;
  assign cmd_frame_o = frame_q;

endmodule

// File: rtl/core/cfb_serializer.sv
// ----------------------------------------------------------------------------
// cfb_serializer
// Sends a frame one byte per request, folding each data byte into the CRC as
// it leaves, then appends the CRC high and low bytes.
// ----------------------------------------------------------------------------
module cfb_serializer
  import cfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cfb_frame_t cmd_frame_i,
  output logic       take_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       last_byte_o
);

  logic             busy_q, busy_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       data_q [CRC_SPAN];
  logic [7:0]       cur_data;
  logic             out_fire;
  logic             in_data;

  assign out_fire = busy_q && out_ready_i;
  assign in_data  = idx_q < BYTE_CRC_HI;

  // A new frame is loaded when idle or as the last byte is taken.
  assign take_o = !busy_q || (out_ready_i && idx_q == BYTE_LAST);

  assign cur_data = data_q[idx_q[POS_W-1:0]];

  // Counter, busy flag and running CRC.
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    crc_d  = crc_q;
    if (take_o) begin
      busy_d = cmd_valid_i;
      idx_d  = BYTE_FIRST;
      crc_d  = CRC_INIT;
    end else if (out_fire) begin
      idx_d = idx_q + IDX_W'(1);
      if (in_data) begin
        crc_d = crc_feed(crc_q, cur_data);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= BYTE_FIRST;
      crc_q  <= CRC_INIT;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      crc_q  <= crc_d;
    end
  end

  // Frame data bytes, loaded whole when a new command is taken.
  always_ff @(posedge clk_i) begin
    if (take_o && cmd_valid_i) begin
      data_q[0] <= cmd_frame_i.frame_address;
      data_q[1] <= cmd_frame_i.frame_function;
      data_q[2] <= cmd_frame_i.command_code;
      data_q[3] <= cmd_frame_i.value_byte_one;
      data_q[4] <= cmd_frame_i.value_byte_two;
      data_q[5] <= cmd_frame_i.value_byte_three;
      data_q[6] <= cmd_frame_i.value_byte_four;
    end
  end

  // Output byte selection: data bytes, then CRC high, then CRC low.
  always_comb begin
    if (in_data) begin
      frame_byte_o = cur_data;
    end else if (idx_q == BYTE_CRC_HI) begin
      frame_byte_o = crc_q[15:8];
    end else begin
      frame_byte_o = crc_q[7:0];
    end
  end

  assign out_valid_o = busy_q;
  assign last_byte_o = idx_q == BYTE_LAST;

endmodule

// File: rtl/core/command_frame_crc16_builder.sv
// ----------------------------------------------------------------------------
// command_frame_crc16_builder
// Builds a nine-byte command frame with a trailing Modbus-style CRC-16.
// ----------------------------------------------------------------------------
// Each accepted command produces nine frame bytes, one per output request:
// address, function, command code, four value bytes, CRC high, CRC low, with
// last_byte_o set on the CRC low byte. The output runs at one byte per cycle
// while out_ready_i is high; a new command is taken as the last byte of a
// frame is taken. One further command is held in the input register while a
// frame drains, and the first byte of a frame is presented in the cycle after
// the command reaches the serialiser. The address and function header bytes
// are captured when the command is accepted.
module command_frame_crc16_builder
  import cfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] command_code_i,
  input  logic [7:0] value_byte_one_i,
  input  logic [7:0] value_byte_two_i,
  input  logic [7:0] value_byte_three_i,
  input  logic [7:0] value_byte_four_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       last_byte_o
);

  logic [7:0] frame_address_q;
  logic [7:0] frame_function_q;
  cfb_frame_t in_frame;
  cfb_frame_t cmd_frame;
  logic       cmd_valid;
  logic       take;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_address_q  <= FRAME_ADDRESS_RST;
      frame_function_q <= FRAME_FUNCTION_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_ADDRESS:  frame_address_q  <= cfg_data_i;
        REG_FRAME_FUNCTION: frame_function_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Assemble the covered part of the frame.
  always_comb begin
    in_frame.frame_address    = frame_address_q;
    in_frame.frame_function   = frame_function_q;
    in_frame.command_code     = command_code_i;
    in_frame.value_byte_one   = value_byte_one_i;
    in_frame.value_byte_two   = value_byte_two_i;
    in_frame.value_byte_three = value_byte_three_i;
    in_frame.value_byte_four  = value_byte_four_i;
  end

  cfb_cmd_stage u_cmd_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_frame_i  (in_frame),
    .take_i      (take),
    .cmd_valid_o (cmd_valid),
    .cmd_frame_o (cmd_frame)
  );

  cfb_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_frame_i  (cmd_frame),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

  // A stalled input can only mean a frame is still being sent.
  a_stall_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while serialiser idle");

  // Within a frame, every byte but the last is followed by another.
  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_byte_o |=> out_valid_o)
    else $error("frame ended early");

  // After the last byte the next frame starts exactly when a command waited.
  a_next_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_byte_o |=> out_valid_o == $past(cmd_valid))
    else $error("pending command lost or frame invented");

  // A byte held back by the receiver stays as it was.
  a_hold_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_byte_o)
      && $stable(last_byte_o))
    else $error("stalled output byte changed");

endmodule
